// ----- rtl/vgcs_pkg.sv -----
// Shared types, constants and cell tables of the voxel grid cell splitter.
package vgcs_pkg;

  localparam int IDX_W     = 24;
  localparam int CELL_W    = 27;
  localparam int SUM_W     = 19;
  localparam int PLANE_W   = 18;
  localparam int MAX_CELLS = 5;

  typedef enum logic [1:0] {
    KIND_HEX   = 2'd0,
    KIND_TET   = 2'd1,
    KIND_WEDGE = 2'd2,
    KIND_NONE  = 2'd3
  } cell_kind_e;

  typedef enum logic [2:0] {
    REG_SIZE_X    = 3'd0,
    REG_SIZE_Y    = 3'd1,
    REG_SIZE_Z    = 3'd2,
    REG_CELL_KIND = 3'd3,
    REG_THRESH_LO = 3'd4,
    REG_THRESH_HI = 3'd5
  } cfg_reg_e;

  typedef enum logic [2:0] {
    FS_IDLE,
    FS_RD0,
    FS_RD1,
    FS_RD2,
    FS_PUSH
  } front_state_e;

  localparam logic [3:0] TYPE_TET   = 4'h0a;
  localparam logic [3:0] TYPE_HEX   = 4'h0c;
  localparam logic [3:0] TYPE_WEDGE = 4'h0d;

  localparam logic [2:0] HEX_CORNER [8] = '{3'd0, 3'd1, 3'd3, 3'd2, 3'd4, 3'd5, 3'd7, 3'd6};
  localparam logic [2:0] TET_CORNER [5][4] = '{
    '{3'd0, 3'd1, 3'd3, 3'd5},
    '{3'd3, 3'd2, 3'd0, 3'd6},
    '{3'd5, 3'd4, 3'd6, 3'd0},
    '{3'd6, 3'd7, 3'd5, 3'd3},
    '{3'd0, 3'd3, 3'd6, 3'd5}
  };
  localparam logic [2:0] WEDGE_CORNER [2][6] = '{
    '{3'd0, 3'd1, 3'd3, 3'd4, 3'd5, 3'd7},
    '{3'd3, 3'd2, 3'd0, 3'd7, 3'd6, 3'd4}
  };

  typedef struct packed {
    logic [8:0]  size_x;
    logic [8:0]  size_y;
    logic [8:0]  size_z;
    cell_kind_e  kind;
    logic [15:0] thresh_lo;
    logic [15:0] thresh_hi;
  } cfg_t;

  typedef struct packed {
    logic [MAX_CELLS-1:0] keep;
    cell_kind_e           kind;
    logic [CELL_W-1:0]    cell_base;
    logic [IDX_W-1:0]     base;
    logic [8:0]           sx;
    logic [PLANE_W-1:0]   plane;
  } cube_job_t;

  function automatic logic [2:0] kind_cells(input cell_kind_e kind);
    logic [2:0] n;
    unique case (kind)
      KIND_HEX:   n = 3'd1;
      KIND_TET:   n = 3'd5;
      KIND_WEDGE: n = 3'd2;
      KIND_NONE:  n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [3:0] kind_verts(input cell_kind_e kind);
    logic [3:0] n;
    unique case (kind)
      KIND_HEX:   n = 4'd8;
      KIND_TET:   n = 4'd4;
      KIND_WEDGE: n = 4'd6;
      KIND_NONE:  n = 4'd0;
    endcase
    return n;
  endfunction

  function automatic logic [3:0] kind_code(input cell_kind_e kind);
    logic [3:0] code;
    unique case (kind)
      KIND_HEX:   code = TYPE_HEX;
      KIND_TET:   code = TYPE_TET;
      KIND_WEDGE: code = TYPE_WEDGE;
      KIND_NONE:  code = TYPE_HEX;
    endcase
    return code;
  endfunction

  // Cube corner of vertex v of cell c; zero where the kind has no such vertex.
  function automatic logic [2:0] corner_of(input cell_kind_e kind, input logic [2:0] c,
                                           input logic [2:0] v);
    logic [2:0] k;
    k = 3'd0;
    unique case (kind)
      KIND_HEX:   k = HEX_CORNER[v];
      KIND_TET:   if (c < 3'd5 && v < 3'd4) k = TET_CORNER[c][v[1:0]];
      KIND_WEDGE: if (c < 3'd2 && v < 3'd6) k = WEDGE_CORNER[c[0]][v];
      KIND_NONE:  k = 3'd0;
    endcase
    return k;
  endfunction

  // Threshold times the vertex count of the kind.
  function automatic logic [SUM_W-1:0] thresh_scale(input cell_kind_e kind,
                                                    input logic [15:0] th);
    logic [SUM_W-1:0] t;
    t = SUM_W'(th);
    unique case (kind)
      KIND_HEX:   t = t << 3;
      KIND_TET:   t = t << 2;
      KIND_WEDGE: t = (t << 2) + (t << 1);
      KIND_NONE:  t = '0;
    endcase
    return t;
  endfunction

endpackage

// ----- rtl/voxel_grid_cell_splitter.sv -----
// Top level of the voxel grid cell splitter: configuration registers and block wiring.
//
// Samples enter on in_valid_i/in_ready_o in raster order, x fastest, one per transfer.
// Each sample that completes a voxel cube yields up to five cells (one hexahedron, five
// tetrahedra or two wedges) on out_valid_o/out_ready_i; cells outside the average band
// are dropped, and cube_last_o marks the last kept cell of the cube.
// Throughput: samples that complete no cube are taken one per cycle in the idle state.
// A cube-completing sample holds the input through states RD0, RD1, RD2 and PUSH: the
// two-port delay memory needs three read rounds for the six stored corners, then the keep
// test runs. The back end emits one cell per cycle, unless out_ready_i stalls it, from a
// two-entry job queue, so output stalls hold the front only once the queue fills.
// Reset restores the default registers (2x2x2 grid, hexahedra, full band) and the
// position counters; the delay memory is not cleared and needs no clearing pass.
// Configuration writes (cfg_we_i, cfg_index_i, cfg_data_i) take effect at once and
// belong between volumes while the block is idle; unknown indexes are ignored.
module voxel_grid_cell_splitter import vgcs_pkg::*; #(
  parameter int DIM_MAX     = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] sample_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [26:0] cell_index_o,
  output logic [23:0] vert_a_o,
  output logic [23:0] vert_b_o,
  output logic [23:0] vert_c_o,
  output logic [23:0] vert_d_o,
  output logic [23:0] vert_e_o,
  output logic [23:0] vert_f_o,
  output logic [23:0] vert_g_o,
  output logic [23:0] vert_h_o,
  output logic [3:0]  vert_count_o,
  output logic [3:0]  type_code_o,
  output logic        cube_last_o
);

  cfg_t       cfg_q;
  logic       push, full, job_valid, pop;
  cube_job_t  job_in, job_head;
  logic [7:0][IDX_W-1:0] verts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.size_x    <= 9'd2;
      cfg_q.size_y    <= 9'd2;
      cfg_q.size_z    <= 9'd2;
      cfg_q.kind      <= KIND_HEX;
      cfg_q.thresh_lo <= 16'd0;
      cfg_q.thresh_hi <= 16'hffff;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_SIZE_X:    cfg_q.size_x    <= cfg_data_i[8:0];
        REG_SIZE_Y:    cfg_q.size_y    <= cfg_data_i[8:0];
        REG_SIZE_Z:    cfg_q.size_z    <= cfg_data_i[8:0];
        REG_CELL_KIND: cfg_q.kind      <= cell_kind_e'(cfg_data_i[1:0]);
        REG_THRESH_LO: cfg_q.thresh_lo <= cfg_data_i;
        REG_THRESH_HI: cfg_q.thresh_hi <= cfg_data_i;
        default: ;
      endcase
    end
  end

  vgcs_front #(
    .DIM_MAX     (DIM_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sample_i   (sample_value_i),
    .push_o     (push),
    .job_o      (job_in),
    .full_i     (full)
  );

  vgcs_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (job_valid),
    .data_o  (job_head)
  );

  vgcs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (job_valid),
    .job_i        (job_head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .cell_index_o (cell_index_o),
    .verts_o      (verts),
    .vert_count_o (vert_count_o),
    .type_code_o  (type_code_o),
    .cube_last_o  (cube_last_o)
  );

  assign vert_a_o = verts[0];
  assign vert_b_o = verts[1];
  assign vert_c_o = verts[2];
  assign vert_d_o = verts[3];
  assign vert_e_o = verts[4];
  assign vert_f_o = verts[5];
  assign vert_g_o = verts[6];
  assign vert_h_o = verts[7];

endmodule

// ----- rtl/vgcs_front.sv -----
// Front end: delay line, position tracking, corner fetch and cell keep test.
module vgcs_front import vgcs_pkg::*; #(
  parameter int DIM_MAX     = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] sample_i,
  output logic        push_o,
  output cube_job_t   job_o,
  input  logic        full_i
);

  localparam int SW      = (SAMPLE_BITS < 16) ? SAMPLE_BITS : 16;
  localparam int DEPTH   = (DIM_MAX + 1) * (DIM_MAX + 1);
  localparam int AW      = $clog2(DEPTH);
  localparam int DIM_CAP = (DIM_MAX > 511) ? 511 : DIM_MAX;
  localparam logic [8:0]    CAP9    = 9'(DIM_CAP);
  localparam logic [AW-1:0] WP_LAST = AW'(DEPTH - 1);
  localparam logic [AW:0]   DEPTH_X = (AW + 1)'(DEPTH);

  function automatic logic [8:0] clamp_size(input logic [8:0] r);
    logic [8:0] s;
    s = r;
    if (r < 9'd2) s = 9'd2;
    else if (r > CAP9) s = CAP9;
    return s;
  endfunction

  function automatic logic [AW-1:0] back_addr(input logic [AW-1:0] wp, input logic [AW:0] off);
    logic [AW:0] d;
    d = {1'b0, wp} - off;
    if (d[AW]) d = d + DEPTH_X;
    return d[AW-1:0];
  endfunction

  front_state_e st_q, st_d;

  logic [8:0] sx, sy, sz;
  logic       acc, cube_hit;

  logic [8:0]       pos_x_q, pos_y_q, pos_z_q, pos_x_d, pos_y_d, pos_z_d;
  logic [IDX_W-1:0] pcount_q, pcount_d;
  logic [AW-1:0]    wp_q, wp_d;

  logic [SW-1:0] mem_q [DEPTH];
  logic [SW-1:0] rd_a_q, rd_b_q;
  logic [AW-1:0] ra, rb;
  logic [AW:0]   off_a, off_b;

  logic [SW-1:0] prev_q, c7_q, c6_q, c5_q, c4_q, c3_q, c2_q;
  logic [AW-1:0] item_wp_q;
  logic [8:0]    bx_q, by_q, bz_q, isx_q, isy_q;
  cell_kind_e    kind_q;

  logic [PLANE_W-1:0] plane_q, pm_q, bysx_q, bycube_q;
  logic [SUM_W-1:0]   lon_q, hin_q;
  logic [CELL_W-1:0]  bzp_q, bzc_q, cube_q;
  logic [IDX_W-1:0]   base_q;

  logic [SW-1:0]        cs [8];
  logic [MAX_CELLS-1:0] keep;
  logic [CELL_W-1:0]    cell_base;

  assign sx  = clamp_size(cfg_i.size_x);
  assign sy  = clamp_size(cfg_i.size_y);
  assign sz  = clamp_size(cfg_i.size_z);
  assign acc = in_valid_i && in_ready_o;

  assign cube_hit = (cfg_i.kind != KIND_NONE) && (pos_x_q != 9'd0) && (pos_x_q < sx)
                 && (pos_y_q != 9'd0) && (pos_y_q < sy) && (pos_z_q != 9'd0) && (pos_z_q < sz);

  // Advance raster position; wrap everything at the end of the volume.
  always_comb begin
    pos_x_d  = pos_x_q;
    pos_y_d  = pos_y_q;
    pos_z_d  = pos_z_q;
    pcount_d = pcount_q;
    wp_d     = wp_q;
    if (acc) begin
      pcount_d = pcount_q + IDX_W'(1);
      wp_d     = (wp_q == WP_LAST) ? '0 : wp_q + AW'(1);
      if ({1'b0, pos_x_q} + 10'd1 >= {1'b0, sx}) begin
        pos_x_d = '0;
        if ({1'b0, pos_y_q} + 10'd1 >= {1'b0, sy}) begin
          pos_y_d = '0;
          if ({1'b0, pos_z_q} + 10'd1 >= {1'b0, sz}) begin
            pos_z_d  = '0;
            pcount_d = '0;
            wp_d     = '0;
          end else begin
            pos_z_d = pos_z_q + 9'd1;
          end
        end else begin
          pos_y_d = pos_y_q + 9'd1;
        end
      end else begin
        pos_x_d = pos_x_q + 9'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= FS_IDLE;
      pos_x_q  <= '0;
      pos_y_q  <= '0;
      pos_z_q  <= '0;
      pcount_q <= '0;
      wp_q     <= '0;
    end else begin
      st_q     <= st_d;
      pos_x_q  <= pos_x_d;
      pos_y_q  <= pos_y_d;
      pos_z_q  <= pos_z_d;
      pcount_q <= pcount_d;
      wp_q     <= wp_d;
    end
  end

  // Corner offsets back from the newest sample: sx, sx+1, plane, plane+1, plane+sx, plane+sx+1.
  // Keep the last pair addressed while waiting to push so the read data holds.
  always_comb begin
    off_a = '0;
    off_b = '0;
    unique case (st_q)
      FS_RD0: begin
        off_a = (AW + 1)'(isx_q);
        off_b = (AW + 1)'(isx_q) + (AW + 1)'(1);
      end
      FS_RD1: begin
        off_a = (AW + 1)'(plane_q);
        off_b = (AW + 1)'(plane_q) + (AW + 1)'(1);
      end
      FS_RD2, FS_PUSH: begin
        off_a = (AW + 1)'(plane_q) + (AW + 1)'(isx_q);
        off_b = (AW + 1)'(plane_q) + (AW + 1)'(isx_q) + (AW + 1)'(1);
      end
      FS_IDLE: begin
        off_a = '0;
        off_b = '0;
      end
    endcase
  end

  assign ra = back_addr(item_wp_q, off_a);
  assign rb = back_addr(item_wp_q, off_b);

  always_ff @(posedge clk_i) begin
    if (acc) mem_q[wp_q] <= sample_i[SW-1:0];
    rd_a_q <= mem_q[ra];
    rd_b_q <= mem_q[rb];
  end

  // Item registers and the index arithmetic, one multiply deep per stage.
  always_ff @(posedge clk_i) begin
    if (acc) begin
      prev_q    <= sample_i[SW-1:0];
      c7_q      <= sample_i[SW-1:0];
      c6_q      <= prev_q;
      item_wp_q <= wp_q;
      bx_q      <= pos_x_q - 9'd1;
      by_q      <= pos_y_q - 9'd1;
      bz_q      <= pos_z_q - 9'd1;
      isx_q     <= sx;
      isy_q     <= sy;
      kind_q    <= cfg_i.kind;
    end
    if (st_q == FS_RD0) begin
      plane_q  <= isx_q * isy_q;
      pm_q     <= (isx_q - 9'd1) * (isy_q - 9'd1);
      bysx_q   <= by_q * isx_q;
      bycube_q <= by_q * (isx_q - 9'd1);
      lon_q    <= thresh_scale(kind_q, cfg_i.thresh_lo);
      hin_q    <= thresh_scale(kind_q, cfg_i.thresh_hi);
    end
    if (st_q == FS_RD1) begin
      c5_q  <= rd_a_q;
      c4_q  <= rd_b_q;
      bzp_q <= CELL_W'(bz_q) * CELL_W'(plane_q);
      bzc_q <= CELL_W'(bz_q) * CELL_W'(pm_q);
    end
    if (st_q == FS_RD2) begin
      c3_q   <= rd_a_q;
      c2_q   <= rd_b_q;
      base_q <= IDX_W'(CELL_W'(bx_q) + CELL_W'(bysx_q) + bzp_q);
      cube_q <= CELL_W'(bx_q) + CELL_W'(bycube_q) + bzc_q;
    end
  end

  assign cs[7] = c7_q;
  assign cs[6] = c6_q;
  assign cs[5] = c5_q;
  assign cs[4] = c4_q;
  assign cs[3] = c3_q;
  assign cs[2] = c2_q;
  assign cs[1] = rd_a_q;
  assign cs[0] = rd_b_q;

  // Sum each cell's corners and test the average band.
  always_comb begin
    logic [SUM_W-1:0] sum;
    keep = '0;
    for (int j = 0; j < MAX_CELLS; j++) begin
      sum = '0;
      for (int v = 0; v < 8; v++) begin
        if (4'(v) < kind_verts(kind_q))
          sum = sum + SUM_W'(cs[corner_of(kind_q, 3'(j), 3'(v))]);
      end
      keep[j] = (3'(j) < kind_cells(kind_q)) && (sum >= lon_q) && (sum <= hin_q);
    end
  end

  always_comb begin
    unique case (kind_q)
      KIND_HEX:   cell_base = cube_q;
      KIND_TET:   cell_base = (cube_q << 2) + cube_q;
      KIND_WEDGE: cell_base = cube_q << 1;
      KIND_NONE:  cell_base = '0;
    endcase
  end

  always_comb begin
    job_o.keep      = keep;
    job_o.kind      = kind_q;
    job_o.cell_base = cell_base;
    job_o.base      = base_q;
    job_o.sx        = isx_q;
    job_o.plane     = plane_q;
  end

  // Next state.
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      FS_IDLE: if (acc && cube_hit) st_d = FS_RD0;
      FS_RD0:  st_d = FS_RD1;
      FS_RD1:  st_d = FS_RD2;
      FS_RD2:  st_d = FS_PUSH;
      FS_PUSH: if (keep == '0 || !full_i) st_d = FS_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready_o = 1'b0;
    push_o     = 1'b0;
    unique case (st_q)
      FS_IDLE: in_ready_o = 1'b1;
      FS_PUSH: push_o = (keep != '0) && !full_i;
      FS_RD0, FS_RD1, FS_RD2: begin
        in_ready_o = 1'b0;
        push_o     = 1'b0;
      end
    endcase
  end

  a_fetch_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == FS_RD0) |-> $past(acc))
    else $error("corner fetch started without an accepted sample");

endmodule

// ----- rtl/vgcs_fifo.sv -----
// Two-entry queue of cube jobs between the front and back ends.
module vgcs_fifo import vgcs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  cube_job_t data_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      valid_o,
  output cube_job_t data_o
);

  cube_job_t  slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("job queue underflow");

endmodule

// ----- rtl/vgcs_back.sv -----
// Back end: walks the kept cells of a cube job and fills the result register.
module vgcs_back import vgcs_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   job_valid_i,
  input  cube_job_t              job_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [CELL_W-1:0]      cell_index_o,
  output logic [7:0][IDX_W-1:0]  verts_o,
  output logic [3:0]             vert_count_o,
  output logic [3:0]             type_code_o,
  output logic                   cube_last_o
);

  logic [MAX_CELLS-1:0] done_q, done_d, rem, pick;
  logic [2:0]           cell_sel;
  logic                 last, emit, valid_q;
  logic [7:0][IDX_W-1:0] verts;

  assign rem = job_i.keep & ~done_q;

  // Take the lowest pending cell.
  always_comb begin
    pick     = '0;
    cell_sel = '0;
    for (int j = MAX_CELLS - 1; j >= 0; j--) begin
      if (rem[j]) begin
        pick     = MAX_CELLS'(1) << j;
        cell_sel = 3'(j);
      end
    end
  end

  assign last  = (rem & ~pick) == '0;
  assign emit  = job_valid_i && (!valid_q || out_ready_i);
  assign pop_o = emit && last;

  always_comb begin
    logic [2:0] k;
    for (int v = 0; v < 8; v++) begin
      k = corner_of(job_i.kind, cell_sel, 3'(v));
      verts[v] = '0;
      if (4'(v) < kind_verts(job_i.kind))
        verts[v] = job_i.base + IDX_W'(k[0]) + (k[1] ? IDX_W'(job_i.sx) : '0)
                 + (k[2] ? IDX_W'(job_i.plane) : '0);
    end
  end

  always_comb begin
    done_d = done_q;
    if (emit) done_d = last ? '0 : (done_q | pick);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      done_q  <= '0;
    end else begin
      done_q <= done_d;
      if (emit) valid_q <= 1'b1;
      else if (out_ready_i) valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      cell_index_o <= job_i.cell_base + CELL_W'(cell_sel);
      verts_o      <= verts;
      vert_count_o <= kind_verts(job_i.kind);
      type_code_o  <= kind_code(job_i.kind);
      cube_last_o  <= last;
    end
  end

  assign out_valid_o = valid_q;

  a_pop_has_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_valid_i && !pop_o) |-> (rem != '0))
    else $error("queued job has no cell left to emit");

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench of the voxel grid cell splitter: random volumes, cell prediction.
`timescale 1ns / 100ps

module tb_top;
  import vgcs_pkg::*;

  localparam int DELAY_DEPTH = 257 * 257;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    bit [26:0] cell_index;
    bit [23:0] vert [8];
    bit [3:0]  vert_count;
    bit [3:0]  type_code;
    bit        cube_last;
  } cell_t;

  class cell_board;
    bit [15:0] delay_mem [DELAY_DEPTH];
    int unsigned px, py, pz, point_idx;
    int unsigned reg_sx, reg_sy, reg_sz, th_lo, th_hi;
    cell_kind_e kind;
    cell_t cells_due[$];
    int errors;

    function new();
      px = 0; py = 0; pz = 0; point_idx = 0;
      reg_sx = 2; reg_sy = 2; reg_sz = 2;
      kind = KIND_HEX; th_lo = 0; th_hi = 65535;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, bit [15:0] data);
      case (idx)
        REG_SIZE_X:    reg_sx = data[8:0];
        REG_SIZE_Y:    reg_sy = data[8:0];
        REG_SIZE_Z:    reg_sz = data[8:0];
        REG_CELL_KIND: kind = cell_kind_e'(data[1:0]);
        REG_THRESH_LO: th_lo = data;
        REG_THRESH_HI: th_hi = data;
        default: ;
      endcase
    endfunction

    function int unsigned clamp_size(int unsigned r);
      return (r < 2) ? 2 : (r > 256) ? 256 : r;
    endfunction

    function bit at_origin();
      return px == 0 && py == 0 && pz == 0;
    endfunction

    function int unsigned corner(int c, int v);
      case (kind)
        KIND_HEX:   return HEX_CORNER[v];
        KIND_TET:   return TET_CORNER[c][v];
        default:    return WEDGE_CORNER[c][v];
      endcase
    endfunction

    // Predict the cells caused by one accepted sample and advance the position.
    function void note_sample(bit [15:0] s);
      int unsigned sx, sy, sz, ncells, nverts, base, cube, k, off, addr, p;
      bit [3:0] code;
      longint unsigned total;
      cell_t cl;
      int kept;
      sx = clamp_size(reg_sx); sy = clamp_size(reg_sy); sz = clamp_size(reg_sz);
      delay_mem[point_idx % DELAY_DEPTH] = s;
      kept = 0;
      if (kind != KIND_NONE && px >= 1 && px < sx && py >= 1 && py < sy &&
          pz >= 1 && pz < sz) begin
        case (kind)
          KIND_HEX: begin ncells = 1; nverts = 8; code = TYPE_HEX; end
          KIND_TET: begin ncells = 5; nverts = 4; code = TYPE_TET; end
          default:  begin ncells = 2; nverts = 6; code = TYPE_WEDGE; end
        endcase
        base = (px - 1) + (py - 1) * sx + (pz - 1) * sx * sy;
        cube = (px - 1) + (py - 1) * (sx - 1) + (pz - 1) * (sx - 1) * (sy - 1);
        for (int c = 0; c < ncells; c++) begin
          total = 0;
          for (int v = 0; v < nverts; v++) begin
            k = corner(c, v);
            off = (1 - (k & 1)) + (1 - ((k >> 1) & 1)) * sx + (1 - ((k >> 2) & 1)) * sx * sy;
            addr = (point_idx % DELAY_DEPTH + DELAY_DEPTH - off) % DELAY_DEPTH;
            total += delay_mem[addr];
          end
          if (total < longint'(th_lo) * nverts || total > longint'(th_hi) * nverts)
            continue;
          cl.cell_index = 27'(ncells * cube + c);
          for (int v = 0; v < 8; v++) begin
            p = 0;
            if (v < nverts) begin
              k = corner(c, v);
              p = base + (k & 1) + ((k >> 1) & 1) * sx + ((k >> 2) & 1) * sx * sy;
            end
            cl.vert[v] = 24'(p);
          end
          cl.vert_count = 4'(nverts);
          cl.type_code = code;
          cl.cube_last = 1'b0;
          cells_due.push_back(cl);
          kept++;
        end
        if (kept > 0) cells_due[$].cube_last = 1'b1;
      end
      px++;
      point_idx = (point_idx + 1) & 24'hFFFFFF;
      if (px >= sx) begin
        px = 0; py++;
        if (py >= sy) begin
          py = 0; pz++;
          if (pz >= sz) begin
            pz = 0; point_idx = 0;
          end
        end
      end
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_cell(cell_t got);
      cell_t want;
      if (cells_due.size() == 0) begin
        report($sformatf("unexpected cell %0d", got.cell_index));
        return;
      end
      want = cells_due.pop_front();
      if (got.cell_index != want.cell_index)
        report($sformatf("cell_index %0d, want %0d", got.cell_index, want.cell_index));
      for (int v = 0; v < 8; v++)
        if (got.vert[v] != want.vert[v])
          report($sformatf("cell %0d vertex %0d: %0d, want %0d", want.cell_index, v,
                           got.vert[v], want.vert[v]));
      if (got.vert_count != want.vert_count)
        report($sformatf("cell %0d vert_count %0d, want %0d", want.cell_index,
                         got.vert_count, want.vert_count));
      if (got.type_code != want.type_code)
        report($sformatf("cell %0d type_code %0d, want %0d", want.cell_index,
                         got.type_code, want.type_code));
      if (got.cube_last != want.cube_last)
        report($sformatf("cell %0d cube_last %0b, want %0b", want.cell_index,
                         got.cube_last, want.cube_last));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [15:0] sample_value_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [26:0] cell_index_o;
  logic [23:0] vert_a_o, vert_b_o, vert_c_o, vert_d_o;
  logic [23:0] vert_e_o, vert_f_o, vert_g_o, vert_h_o;
  logic [3:0]  vert_count_o;
  logic [3:0]  type_code_o;
  logic        cube_last_o;

  cell_board board = new();
  bit calm = 1'b0;
  bit hold_req = 1'b0;
  int cycles = 0;

  voxel_grid_cell_splitter dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 5);
  endfunction

  task automatic write_reg(logic [2:0] idx, bit [15:0] data);
    @(negedge clk_i);
    cfg_we_i = 1'b1; cfg_index_i = idx; cfg_data_i = data;
    board.write_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic send_sample(bit [15:0] s);
    int gap;
    gap = draw_gap();
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    sample_value_i = s;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_sample(s);
  endtask

  // Hold the sender until every predicted cell has arrived, then let the block settle.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (board.cells_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Send at least min_items samples, then finish the current volume.
  task automatic send_volume_run(int min_items);
    int sent;
    sent = 0;
    while (sent < min_items || !board.at_origin()) begin
      send_sample(16'($urandom));
      sent++;
    end
  endtask

  initial begin : receiver
    cell_t got;
    int gap;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        @(negedge clk_i);
        out_ready_i = 1'b0;
        repeat (300) @(posedge clk_i);
      end
      gap = draw_gap();
      repeat (gap) begin
        @(negedge clk_i);
        out_ready_i = 1'b0;
      end
      @(negedge clk_i);
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      got.cell_index = cell_index_o;
      got.vert = '{vert_a_o, vert_b_o, vert_c_o, vert_d_o,
                   vert_e_o, vert_f_o, vert_g_o, vert_h_o};
      got.vert_count = vert_count_o;
      got.type_code = type_code_o;
      got.cube_last = cube_last_o;
      board.check_cell(got);
    end
  end

  initial begin : stimulus
    int unsigned lo, hi;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Default 2x2x2 hexahedron, corners at both sample extremes.
    for (int i = 0; i < 8; i++) send_sample(i[0] ? 16'hFFFF : 16'h0000);
    drain();
    // Tetrahedra with the band pinned at the top value, inclusive.
    write_reg(REG_CELL_KIND, 16'(KIND_TET));
    write_reg(REG_THRESH_LO, 16'hFFFF);
    write_reg(REG_THRESH_HI, 16'hFFFF);
    for (int i = 0; i < 8; i++) send_sample(16'hFFFF);
    drain();
    // Wedges with an empty band: nothing kept.
    write_reg(REG_CELL_KIND, 16'(KIND_WEDGE));
    write_reg(REG_THRESH_LO, 16'd1);
    write_reg(REG_THRESH_HI, 16'd0);
    for (int i = 0; i < 8; i++) send_sample(16'($urandom));
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      calm = (ph % 3 == 0);
      if (ph == 4) begin
        // Many tetrahedra while the receiver holds off, so the queue fills.
        write_reg(REG_SIZE_X, 16'd4);
        write_reg(REG_SIZE_Y, 16'd3);
        write_reg(REG_SIZE_Z, 16'd2);
        write_reg(REG_CELL_KIND, 16'(KIND_TET));
        write_reg(REG_THRESH_LO, 16'd0);
        write_reg(REG_THRESH_HI, 16'hFFFF);
        hold_req = 1'b1;
      end else begin
        write_reg(REG_SIZE_X, 16'($urandom_range(0, 4)));
        write_reg(REG_SIZE_Y, 16'($urandom_range(0, 3)));
        write_reg(REG_SIZE_Z, 16'($urandom_range(0, 2)));
        write_reg(REG_CELL_KIND,
                  (ph == 1) ? 16'(KIND_NONE) : 16'($urandom_range(0, 2)));
        case ($urandom_range(0, 2))
          0: begin lo = 0; hi = 65535; end
          1: begin lo = $urandom_range(20000, 32768); hi = $urandom_range(32768, 45000); end
          default: begin lo = $urandom_range(0, 65535); hi = $urandom_range(lo, 65535); end
        endcase
        write_reg(REG_THRESH_LO, 16'(lo));
        write_reg(REG_THRESH_HI, 16'(hi));
        if (ph % 4 == 2) write_reg(3'($urandom_range(6, 7)), 16'($urandom));
      end
      send_volume_run(1);
      drain();
    end

    if (board.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
